FILE: sv/vtpg_pkg.sv
package vtpg_pkg;

    // Field and register widths fixed by the interface.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;
    localparam int DIM_CFG_W  = 12;
    localparam int STEP_W     = 25;
    localparam int COORD_W    = 11;
    localparam int CHAN_W     = 8;
    localparam int BAR_W      = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_SELECT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_STEP         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP         = 3'd4;

    // Configuration values after reset.
    localparam logic [DIM_CFG_W-1:0] RST_FRAME_WIDTH  = 12'd640;
    localparam logic [DIM_CFG_W-1:0] RST_FRAME_HEIGHT = 12'd480;
    localparam logic                 RST_PATTERN      = 1'b1;
    localparam logic [STEP_W-1:0]    RST_X_STEP       = 25'd184365;
    localparam logic [STEP_W-1:0]    RST_Y_STEP       = 25'd69905;

    // Pattern codes.
    localparam logic PATTERN_BANDS = 1'b0;
    localparam logic PATTERN_BARS  = 1'b1;

    // Bar index: the first bar, the last colored bar, the saturation value,
    // and the index bits that enable each channel.
    localparam logic [BAR_W-1:0] BAR_FIRST = 4'd1;
    localparam logic [BAR_W-1:0] BAR_LAST  = 4'd7;
    localparam logic [BAR_W-1:0] BAR_SAT   = 4'd8;
    localparam int BAR_RED_BIT   = 0;
    localparam int BAR_BLUE_BIT  = 1;
    localparam int BAR_GREEN_BIT = 2;

    localparam logic [CHAN_W-1:0] CHAN_FULL = 8'd255;

    // Operation of a saturating accumulator unit.
    typedef enum logic {
        ACC_ADD,
        ACC_SUB
    } t_acc_op;

endpackage

FILE: sv/vtpg_sat_acc.sv
module vtpg_sat_acc #(
    parameter int ACC_W = 26
) (
    input  logic [ACC_W-1:0]           i_acc,
    input  logic [vtpg_pkg::STEP_W-1:0] i_step,
    input  vtpg_pkg::t_acc_op          i_op,
    output logic [ACC_W-1:0]           o_result
);
    import vtpg_pkg::*;

    localparam int SUM_W = ((ACC_W > STEP_W) ? ACC_W : STEP_W) + 1;
    localparam logic [SUM_W-1:0] ACC_MAX = SUM_W'({ACC_W{1'b1}});

    logic [SUM_W-1:0] a_ext;
    logic [SUM_W-1:0] b_ext;
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] diff;

    assign a_ext = SUM_W'(i_acc);
    assign b_ext = SUM_W'(i_step);
    assign sum   = a_ext + b_ext;
    assign diff  = a_ext - b_ext;

    // Addition clips at all ones, subtraction clips at zero.
    always_comb begin
        unique case (i_op)
            ACC_ADD: o_result = (sum > ACC_MAX) ? {ACC_W{1'b1}} : ACC_W'(sum);
            ACC_SUB: o_result = (b_ext > a_ext) ? '0 : ACC_W'(diff);
            default: o_result = i_acc;
        endcase
    end

endmodule

FILE: sv/video_test_pattern_generator.sv
// A pixel appears on the output register in the cycle after its transaction is accepted.
// Throughput: one pixel per cycle unless the output stalls; column, line and intensity state
// all update in the same cycle the pixel is taken; intensities saturate on add or subtract.
// The input is stalled only while the output register holds a pixel that is itself stalled.
// Reset (synchronous, active low) restores the register defaults and restarts at pixel (0,0).
module video_test_pattern_generator #(
    parameter int MAX_DIMENSION = 2048,
    parameter int FRACTION_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [vtpg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vtpg_pkg::CFG_DATA_W-1:0] i_cfg_wr_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_frame_start,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [vtpg_pkg::COORD_W-1:0]    o_pixel_x,
    output logic [vtpg_pkg::COORD_W-1:0]    o_pixel_y,
    output logic [vtpg_pkg::CHAN_W-1:0]     o_red_value,
    output logic [vtpg_pkg::CHAN_W-1:0]     o_blue_value,
    output logic [vtpg_pkg::CHAN_W-1:0]     o_green_value,
    output logic                           o_end_of_line,
    output logic                           o_end_of_frame
);
    import vtpg_pkg::*;

    localparam int ACC_W = FRACTION_BITS + 10;
    localparam int CNT_W = $clog2(MAX_DIMENSION);
    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
    localparam int CMP_W = (DIM_W > DIM_CFG_W) ? DIM_W : DIM_CFG_W;
    localparam logic [ACC_W-1:0] FULL_SCALE = ACC_W'(1) << (FRACTION_BITS + 8);
    localparam logic [CMP_W-1:0] MAX_DIM_C  = CMP_W'(MAX_DIMENSION);

    // Integer part of an accumulator, clipped to one byte.
    function automatic logic [CHAN_W-1:0] to_byte(input logic [ACC_W-1:0] acc);
        logic over;
        over = |acc[ACC_W-1:FRACTION_BITS+8];
        return over ? CHAN_FULL : acc[FRACTION_BITS+7:FRACTION_BITS];
    endfunction

    // Width or height clipped to 1..MAX_DIMENSION.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] d);
        logic [CMP_W-1:0] d_ext;
        d_ext = CMP_W'(d);
        if (d_ext == '0) begin
            return DIM_W'(1);
        end else if (d_ext > MAX_DIM_C) begin
            return DIM_W'(MAX_DIM_C);
        end
        return DIM_W'(d_ext);
    endfunction

    // Configuration registers.
    logic [DIM_CFG_W-1:0] r_frame_width;
    logic [DIM_CFG_W-1:0] r_frame_height;
    logic                 r_pattern_select;
    logic [STEP_W-1:0]    r_x_step;
    logic [STEP_W-1:0]    r_y_step;

    // Raster state.
    logic [CNT_W-1:0] r_col;
    logic [CNT_W-1:0] r_line;
    logic [ACC_W-1:0] r_red;
    logic [ACC_W-1:0] r_blue;
    logic [ACC_W-1:0] r_green;
    logic [ACC_W-1:0] r_bar_int;
    logic [BAR_W-1:0] r_bar_idx;

    // Output register.
    logic               r_out_valid;
    logic [COORD_W-1:0] r_out_x;
    logic [COORD_W-1:0] r_out_y;
    logic [CHAN_W-1:0]  r_out_red;
    logic [CHAN_W-1:0]  r_out_blue;
    logic [CHAN_W-1:0]  r_out_green;
    logic               r_out_eol;
    logic               r_out_eof;

    logic             in_acc;
    logic [DIM_W-1:0] dim_w;
    logic [DIM_W-1:0] dim_h;
    logic [DIM_W-1:0] w_last;
    logic [DIM_W-1:0] h_last;
    logic [DIM_W-1:0] h_half;
    logic [DIM_W-1:0] q1;
    logic [DIM_W-1:0] q2;
    logic [DIM_W-1:0] q3;

    // State as seen by this pixel, after an optional frame restart.
    logic [CNT_W-1:0] e_col;
    logic [CNT_W-1:0] e_line;
    logic [ACC_W-1:0] e_red;
    logic [ACC_W-1:0] e_blue;
    logic [ACC_W-1:0] e_green;
    logic [ACC_W-1:0] e_bar_int;
    logic [BAR_W-1:0] e_bar_idx;

    logic        eol;
    logic        eof;
    logic [CHAN_W-1:0] px_red;
    logic [CHAN_W-1:0] px_blue;
    logic [CHAN_W-1:0] px_green;
    logic [CHAN_W-1:0] bar_byte;

    t_acc_op          red_op;
    t_acc_op          blue_op;
    t_acc_op          green_op;
    logic [ACC_W-1:0] red_res;
    logic [ACC_W-1:0] blue_res;
    logic [ACC_W-1:0] green_res;
    logic [ACC_W-1:0] bar_res;

    logic [CNT_W-1:0] n_col;
    logic [CNT_W-1:0] n_line;
    logic [ACC_W-1:0] n_red;
    logic [ACC_W-1:0] n_blue;
    logic [ACC_W-1:0] n_green;
    logic [ACC_W-1:0] n_bar_int;
    logic [BAR_W-1:0] n_bar_idx;

    // Handshake: take a pixel request whenever the output register can be reloaded.
    assign o_stall = r_out_valid && i_stall;
    assign in_acc  = i_valid && !o_stall;

    // Frame geometry.
    assign dim_w  = clamp_dim(r_frame_width);
    assign dim_h  = clamp_dim(r_frame_height);
    assign w_last = dim_w - DIM_W'(1);
    assign h_last = dim_h - DIM_W'(1);
    assign h_half = dim_h >> 1;
    assign q1     = dim_w >> 2;
    assign q2     = q1 << 1;
    assign q3     = q2 + q1;

    // A frame start restarts the raster before this pixel is drawn.
    always_comb begin
        if (i_frame_start) begin
            e_col     = '0;
            e_line    = '0;
            e_red     = FULL_SCALE;
            e_blue    = '0;
            e_green   = '0;
            e_bar_int = '0;
            e_bar_idx = BAR_FIRST;
        end else begin
            e_col     = r_col;
            e_line    = r_line;
            e_red     = r_red;
            e_blue    = r_blue;
            e_green   = r_green;
            e_bar_int = r_bar_int;
            e_bar_idx = r_bar_idx;
        end
    end

    assign eol = DIM_W'(e_col) >= w_last;
    assign eof = eol && (DIM_W'(e_line) >= h_last);

    // Pixel color for the selected pattern.
    assign bar_byte = to_byte(e_bar_int);

    always_comb begin
        if (r_pattern_select == PATTERN_BANDS) begin
            px_red   = to_byte(e_red);
            px_blue  = to_byte(e_blue);
            px_green = to_byte(e_green);
        end else if (e_bar_idx > BAR_LAST) begin
            px_red   = CHAN_FULL;
            px_blue  = CHAN_FULL;
            px_green = CHAN_FULL;
        end else begin
            px_red   = e_bar_idx[BAR_RED_BIT]   ? bar_byte : '0;
            px_blue  = e_bar_idx[BAR_BLUE_BIT]  ? bar_byte : '0;
            px_green = e_bar_idx[BAR_GREEN_BIT] ? bar_byte : '0;
        end
    end

    // Band direction of the red and blue ramps for this column.
    always_comb begin
        priority if (DIM_W'(e_col) < q1) begin
            red_op  = ACC_SUB;
            blue_op = ACC_ADD;
        end else if (DIM_W'(e_col) < q2) begin
            red_op  = ACC_ADD;
            blue_op = ACC_ADD;
        end else if (DIM_W'(e_col) < q3) begin
            red_op  = ACC_SUB;
            blue_op = ACC_SUB;
        end else begin
            red_op  = ACC_ADD;
            blue_op = ACC_ADD;
        end
    end

    // Green rises through the upper half of the frame and falls after.
    assign green_op = (DIM_W'(e_line) < h_half) ? ACC_ADD : ACC_SUB;

    vtpg_sat_acc #(.ACC_W(ACC_W)) u_red_acc (
        .i_acc    (e_red),
        .i_step   (r_x_step),
        .i_op     (red_op),
        .o_result (red_res)
    );

    vtpg_sat_acc #(.ACC_W(ACC_W)) u_blue_acc (
        .i_acc    (e_blue),
        .i_step   (r_x_step),
        .i_op     (blue_op),
        .o_result (blue_res)
    );

    vtpg_sat_acc #(.ACC_W(ACC_W)) u_green_acc (
        .i_acc    (e_green),
        .i_step   (r_y_step),
        .i_op     (green_op),
        .o_result (green_res)
    );

    vtpg_sat_acc #(.ACC_W(ACC_W)) u_bar_acc (
        .i_acc    (e_bar_int),
        .i_step   (r_x_step),
        .i_op     (ACC_ADD),
        .o_result (bar_res)
    );

    // Next raster state: advance a column, wrap a line, or wrap the frame.
    always_comb begin
        n_col     = e_col;
        n_line    = e_line;
        n_red     = e_red;
        n_blue    = e_blue;
        n_green   = e_green;
        n_bar_int = e_bar_int;
        n_bar_idx = e_bar_idx;
        if (eol) begin
            n_col     = '0;
            n_red     = FULL_SCALE;
            n_blue    = '0;
            n_bar_int = '0;
            n_bar_idx = BAR_FIRST;
            if (eof) begin
                n_line  = '0;
                n_green = '0;
            end else begin
                n_line  = e_line + CNT_W'(1);
                n_green = green_res;
            end
        end else begin
            n_col = e_col + CNT_W'(1);
            // The first band holds blue at zero; the last band holds red at zero.
            n_red  = (DIM_W'(e_col) >= q3) ? '0 : red_res;
            n_blue = (DIM_W'(e_col) < q1) ? '0 : blue_res;
            if (bar_res >= FULL_SCALE) begin
                n_bar_int = '0;
                if (e_bar_idx < BAR_SAT) begin
                    n_bar_idx = e_bar_idx + BAR_W'(1);
                end
            end else begin
                n_bar_int = bar_res;
            end
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width    <= RST_FRAME_WIDTH;
            r_frame_height   <= RST_FRAME_HEIGHT;
            r_pattern_select <= RST_PATTERN;
            r_x_step         <= RST_X_STEP;
            r_y_step         <= RST_Y_STEP;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:    r_frame_width    <= i_cfg_wr_data[DIM_CFG_W-1:0];
                CFG_FRAME_HEIGHT:   r_frame_height   <= i_cfg_wr_data[DIM_CFG_W-1:0];
                CFG_PATTERN_SELECT: r_pattern_select <= i_cfg_wr_data[0];
                CFG_X_STEP:         r_x_step         <= i_cfg_wr_data[STEP_W-1:0];
                CFG_Y_STEP:         r_y_step         <= i_cfg_wr_data[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Raster state advances once per accepted transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_line    <= '0;
            r_red     <= FULL_SCALE;
            r_blue    <= '0;
            r_green   <= '0;
            r_bar_int <= '0;
            r_bar_idx <= BAR_FIRST;
        end else if (in_acc) begin
            r_col     <= n_col;
            r_line    <= n_line;
            r_red     <= n_red;
            r_blue    <= n_blue;
            r_green   <= n_green;
            r_bar_int <= n_bar_int;
            r_bar_idx <= n_bar_idx;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_x     <= COORD_W'(e_col);
            r_out_y     <= COORD_W'(e_line);
            r_out_red   <= px_red;
            r_out_blue  <= px_blue;
            r_out_green <= px_green;
            r_out_eol   <= eol;
            r_out_eof   <= eof;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pixel_x      = r_out_x;
    assign o_pixel_y      = r_out_y;
    assign o_red_value    = r_out_red;
    assign o_blue_value   = r_out_blue;
    assign o_green_value  = r_out_green;
    assign o_end_of_line  = r_out_eol;
    assign o_end_of_frame = r_out_eof;

    // The last pixel of a frame is always the last of its line.
    a_eof_has_eol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_eof |-> r_out_eol)
        else $error("end of frame without end of line");

    // A line wrap returns the column counter to zero.
    a_eol_wraps_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && eol |=> r_col == '0)
        else $error("column counter not cleared after end of line");

    // A frame restart emits pixel (0,0).
    a_frame_start_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_frame_start |=> o_valid && o_pixel_x == '0 && o_pixel_y == '0)
        else $error("frame start did not emit the origin pixel");

    // The bar index stays between the first bar and its saturation value.
    a_bar_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bar_idx >= BAR_FIRST && r_bar_idx <= BAR_SAT)
        else $error("bar index out of range");

    // An accepted transaction always leaves a pixel in the output register.
    a_accept_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_out_valid)
        else $error("accepted transaction produced no pixel");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import vtpg_pkg::*;

    localparam int FRAC_W          = 16;
    localparam int ACC_W           = FRAC_W + 10;
    localparam int MAX_DIM         = 2048;
    localparam int RANDOM_PHASES   = 12;
    localparam int PHASE_ITEMS     = 125;
    localparam int HOLD_OFF_CYCLES = 80;
    // Longest quiet stretch of a correct run: the receiver hold-off plus a stall
    // pattern span, a sender gap and a few configuration writes. Taken many times over.
    localparam int QUIET_LIMIT     = 2000;
    localparam logic [ACC_W-1:0] ACC_MAX    = {ACC_W{1'b1}};
    localparam logic [ACC_W-1:0] FULL_SCALE = 26'd256 << FRAC_W;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  blue;
        logic [CHAN_W-1:0]  green;
        logic               line_end;
        logic               frame_end;
    } t_pixel;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wr_data;
    logic                  i_valid;
    logic                  o_stall;
    logic                  i_frame_start;
    logic                  o_valid;
    logic                  i_stall;
    logic [COORD_W-1:0]    o_pixel_x;
    logic [COORD_W-1:0]    o_pixel_y;
    logic [CHAN_W-1:0]     o_red_value;
    logic [CHAN_W-1:0]     o_blue_value;
    logic [CHAN_W-1:0]     o_green_value;
    logic                  o_end_of_line;
    logic                  o_end_of_frame;

    // Mirror of the configuration registers.
    logic [DIM_CFG_W-1:0] frame_w;
    logic [DIM_CFG_W-1:0] frame_h;
    logic                 pattern;
    logic [STEP_W-1:0]    x_step;
    logic [STEP_W-1:0]    y_step;

    // Mirror of the raster and intensity state.
    int unsigned      col_cnt;
    int unsigned      line_cnt;
    logic [ACC_W-1:0] red_acc;
    logic [ACC_W-1:0] blue_acc;
    logic [ACC_W-1:0] green_acc;
    logic [ACC_W-1:0] bar_level;
    logic [BAR_W-1:0] bar_idx;

    t_pixel expected_pixels[$];
    int     mismatch_count = 0;
    int     requests_sent  = 0;
    int     pixels_checked = 0;
    int     quiet_cycles   = 0;
    bit     hold_off_pending = 1'b0;

    video_test_pattern_generator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_frame_start (i_frame_start),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_red_value   (o_red_value),
        .o_blue_value  (o_blue_value),
        .o_green_value (o_green_value),
        .o_end_of_line (o_end_of_line),
        .o_end_of_frame(o_end_of_frame)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Saturating fixed-point helpers.
    function automatic logic [ACC_W-1:0] sat_up(logic [ACC_W-1:0] a, logic [STEP_W-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + (ACC_W+1)'(b);
        return (s > ACC_MAX) ? ACC_MAX : s[ACC_W-1:0];
    endfunction

    function automatic logic [ACC_W-1:0] sat_down(logic [ACC_W-1:0] a, logic [STEP_W-1:0] b);
        return (b > a) ? '0 : a - ACC_W'(b);
    endfunction

    function automatic logic [CHAN_W-1:0] to_chan(logic [ACC_W-1:0] acc);
        logic [ACC_W-FRAC_W-1:0] whole;
        whole = acc[ACC_W-1:FRAC_W];
        return (whole > CHAN_FULL) ? CHAN_FULL : whole[CHAN_W-1:0];
    endfunction

    // A size of zero acts as one; anything above the maximum acts as the maximum.
    function automatic int unsigned fit_dimension(logic [DIM_CFG_W-1:0] d);
        if (d == 0)
            return 1;
        if (d > MAX_DIM)
            return MAX_DIM;
        return 32'(d);
    endfunction

    function automatic void begin_line();
        col_cnt   = 0;
        red_acc   = FULL_SCALE;
        blue_acc  = '0;
        bar_level = '0;
        bar_idx   = BAR_FIRST;
    endfunction

    function automatic void begin_frame();
        begin_line();
        line_cnt  = 0;
        green_acc = '0;
    endfunction

    // Works out the pixel emitted for one accepted transaction and advances the state.
    function automatic t_pixel predict_pixel(logic restart);
        int unsigned       w;
        int unsigned       h;
        int unsigned       q;
        logic [CHAN_W-1:0] level;
        t_pixel            px;
        w = fit_dimension(frame_w);
        h = fit_dimension(frame_h);
        q = w / 4;
        if (restart)
            begin_frame();

        if (pattern == PATTERN_BANDS) begin
            px.red   = to_chan(red_acc);
            px.blue  = to_chan(blue_acc);
            px.green = to_chan(green_acc);
        end else if (bar_idx > BAR_LAST) begin
            px.red   = CHAN_FULL;
            px.blue  = CHAN_FULL;
            px.green = CHAN_FULL;
        end else begin
            level    = to_chan(bar_level);
            px.red   = bar_idx[BAR_RED_BIT]   ? level : '0;
            px.blue  = bar_idx[BAR_BLUE_BIT]  ? level : '0;
            px.green = bar_idx[BAR_GREEN_BIT] ? level : '0;
        end

        px.x         = COORD_W'(col_cnt);
        px.y         = COORD_W'(line_cnt);
        px.line_end  = (col_cnt >= w - 1);
        px.frame_end = px.line_end && (line_cnt >= h - 1);

        if (px.line_end) begin
            if (px.frame_end) begin
                begin_frame();
            end else begin
                // Green ramps up over the top half of the frame and down after.
                if (line_cnt < h / 2)
                    green_acc = sat_up(green_acc, y_step);
                else
                    green_acc = sat_down(green_acc, y_step);
                line_cnt++;
                begin_line();
            end
        end else begin
            if (col_cnt < q) begin
                blue_acc = '0;
                red_acc  = sat_down(red_acc, x_step);
            end else if (col_cnt < 2 * q) begin
                blue_acc = sat_up(blue_acc, x_step);
                red_acc  = sat_up(red_acc, x_step);
            end else if (col_cnt < 3 * q) begin
                blue_acc = sat_down(blue_acc, x_step);
                red_acc  = sat_down(red_acc, x_step);
            end else begin
                blue_acc = sat_up(blue_acc, x_step);
                red_acc  = '0;
            end
            bar_level = sat_up(bar_level, x_step);
            if (bar_level >= FULL_SCALE) begin
                bar_level = '0;
                if (bar_idx < BAR_SAT)
                    bar_idx++;
            end
            col_cnt++;
        end
        return px;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        $display("%0t: %s", $time, msg);
    endtask

    // Writes one configuration register and updates the mirror.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= idx;
        i_cfg_wr_data <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_FRAME_WIDTH:    frame_w = data[DIM_CFG_W-1:0];
            CFG_FRAME_HEIGHT:   frame_h = data[DIM_CFG_W-1:0];
            CFG_PATTERN_SELECT: pattern = data[0];
            CFG_X_STEP:         x_step  = data[STEP_W-1:0];
            CFG_Y_STEP:         y_step  = data[STEP_W-1:0];
            default: ;
        endcase
    endtask

    // Offers one pixel request and holds it until the block takes the transaction.
    task automatic send_pixel_request(logic restart);
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_frame_start <= restart;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        expected_pixels.push_back(predict_pixel(restart));
        requests_sent++;
    endtask

    // Idle cycles on the input side; the payload wanders while nothing is offered.
    task automatic idle_sender(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_valid       <= 1'b0;
            i_frame_start <= 1'($urandom_range(0, 1));
        end
    endtask

    task automatic drain_pipeline();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
    endtask

    // Sends requests in bursts of random length, optionally with gaps between them.
    task automatic send_frame_items(int count, int restart_pct, bit with_gaps);
        int burst_left;
        burst_left = 0;
        for (int n = 0; n < count; n++) begin
            if (burst_left == 0) begin
                if (with_gaps)
                    idle_sender($urandom_range(0, 6));
                burst_left = $urandom_range(1, 16);
            end
            send_pixel_request($urandom_range(0, 99) < restart_pct);
            burst_left--;
        end
    endtask

    // Register defaults after reset, including the first pixel with no restart.
    task automatic test_reset_defaults();
        send_pixel_request(1'b0);
        send_pixel_request(1'b0);
        send_pixel_request(1'b1);
    endtask

    // A size of zero makes every pixel end its line and frame; oversize sizes clamp.
    task automatic test_dimension_clamp();
        drain_pipeline();
        write_reg(CFG_FRAME_WIDTH, '0);
        write_reg(CFG_FRAME_HEIGHT, '0);
        repeat (3) send_pixel_request(1'b0);
        drain_pipeline();
        write_reg(CFG_FRAME_WIDTH, 25'hFFF);
        write_reg(CFG_FRAME_HEIGHT, 25'h801);
        send_pixel_request(1'b1);
        send_pixel_request(1'b0);
    endtask

    // Largest steps drive every band through both saturation limits.
    task automatic test_saturating_bands();
        drain_pipeline();
        write_reg(CFG_FRAME_WIDTH, 25'd8);
        write_reg(CFG_FRAME_HEIGHT, 25'd4);
        write_reg(CFG_PATTERN_SELECT, CFG_DATA_W'(PATTERN_BANDS));
        write_reg(CFG_X_STEP, {STEP_W{1'b1}});
        write_reg(CFG_Y_STEP, {STEP_W{1'b1}});
        send_pixel_request(1'b1);
        repeat (8) send_pixel_request(1'b0);
    endtask

    // A full-scale step advances the bar on every column until it saturates to white.
    // The pattern switch mid-line shows that the bar state kept running underneath.
    task automatic test_bar_saturation();
        drain_pipeline();
        write_reg(CFG_FRAME_WIDTH, 25'd16);
        write_reg(CFG_FRAME_HEIGHT, 25'd2);
        write_reg(CFG_X_STEP, CFG_DATA_W'(FULL_SCALE));
        send_pixel_request(1'b1);
        repeat (2) send_pixel_request(1'b0);
        drain_pipeline();
        write_reg(CFG_PATTERN_SELECT, CFG_DATA_W'(PATTERN_BARS));
        repeat (7) send_pixel_request(1'b0);
    endtask

    // Shrinking the frame below the current position ends line and frame at once;
    // zero steps then keep the ramps flat.
    task automatic test_shrink_mid_frame();
        drain_pipeline();
        write_reg(CFG_FRAME_WIDTH, 25'd5);
        write_reg(CFG_FRAME_HEIGHT, 25'd1);
        write_reg(CFG_X_STEP, '0);
        write_reg(CFG_Y_STEP, '0);
        repeat (3) send_pixel_request(1'b0);
    endtask

    // Random settings per phase, mostly small frames so lines and frames wrap often.
    task automatic test_random_frames();
        logic [CFG_DATA_W-1:0] data;
        int unsigned           span;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_pipeline();

            if (phase == 0 || $urandom_range(0, 9) < 7) begin
                data = CFG_DATA_W'($urandom);
                case ($urandom_range(0, 9))
                    0:       data[DIM_CFG_W-1:0] = DIM_CFG_W'($urandom_range(0, 4095));
                    1:       data[DIM_CFG_W-1:0] = DIM_CFG_W'($urandom_range(1, 2));
                    default: data[DIM_CFG_W-1:0] = DIM_CFG_W'($urandom_range(3, 40));
                endcase
                write_reg(CFG_FRAME_WIDTH, data);
            end
            if (phase == 0 || $urandom_range(0, 9) < 7) begin
                data = CFG_DATA_W'($urandom);
                data[DIM_CFG_W-1:0] = ($urandom_range(0, 9) == 0) ?
                                      DIM_CFG_W'($urandom_range(0, 4095)) :
                                      DIM_CFG_W'($urandom_range(1, 12));
                write_reg(CFG_FRAME_HEIGHT, data);
            end
            if (phase == 0 || $urandom_range(0, 1) == 1)
                write_reg(CFG_PATTERN_SELECT, CFG_DATA_W'($urandom));

            // Steps: flat, largest, any value, or one that fits the band or half height.
            if (phase == 0 || $urandom_range(0, 9) < 7) begin
                span = fit_dimension(frame_w) / 4;
                case ($urandom_range(0, 7))
                    0:       data = '0;
                    1:       data = {CFG_DATA_W{1'b1}};
                    2:       data = CFG_DATA_W'($urandom);
                    default: data = CFG_DATA_W'(FULL_SCALE / ((span == 0) ? 1 : span)
                                                + $urandom_range(0, 255));
                endcase
                write_reg(CFG_X_STEP, data);
            end
            if (phase == 0 || $urandom_range(0, 9) < 7) begin
                span = fit_dimension(frame_h) / 2;
                case ($urandom_range(0, 7))
                    0:       data = '0;
                    1:       data = {CFG_DATA_W{1'b1}};
                    2:       data = CFG_DATA_W'($urandom);
                    default: data = CFG_DATA_W'(FULL_SCALE / ((span == 0) ? 1 : span)
                                                + $urandom_range(0, 255));
                endcase
                write_reg(CFG_Y_STEP, data);
            end

            if (phase == 3)
                hold_off_pending = 1'b1;
            send_pixel_request(1'($urandom_range(0, 1)));
            if (phase == 6) begin
                // Sender pauses until every outstanding pixel has come back.
                send_frame_items(PHASE_ITEMS / 2, 3, 1'b1);
                drain_pipeline();
                send_frame_items(PHASE_ITEMS / 2, 3, 1'b1);
            end else begin
                send_frame_items(PHASE_ITEMS - 1, 3, phase != 9);
            end
        end
    endtask

    // Receiver stall patterns, with one long hold-off on request.
    initial begin : receiver_stall
        int mode;
        int span;
        i_stall = 1'b0;
        forever begin
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                repeat (HOLD_OFF_CYCLES) begin
                    @(negedge i_clk);
                    i_stall <= 1'b1;
                end
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    0:       i_stall <= 1'b0;
                    1:       i_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= ~i_stall;
                endcase
            end
        end
    end

    // Compares each pixel transaction with the oldest expected pixel.
    always @(posedge i_clk) begin : pixel_checker
        t_pixel want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            pixels_checked++;
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("pixel (%0d,%0d) with nothing expected",
                                          o_pixel_x, o_pixel_y));
            end else begin
                want = expected_pixels.pop_front();
                if (o_pixel_x !== want.x)
                    report_mismatch($sformatf("pixel_x %0d, expected %0d", o_pixel_x, want.x));
                if (o_pixel_y !== want.y)
                    report_mismatch($sformatf("pixel_y %0d, expected %0d", o_pixel_y, want.y));
                if (o_red_value !== want.red)
                    report_mismatch($sformatf("red %0d, expected %0d at (%0d,%0d)",
                                              o_red_value, want.red, want.x, want.y));
                if (o_blue_value !== want.blue)
                    report_mismatch($sformatf("blue %0d, expected %0d at (%0d,%0d)",
                                              o_blue_value, want.blue, want.x, want.y));
                if (o_green_value !== want.green)
                    report_mismatch($sformatf("green %0d, expected %0d at (%0d,%0d)",
                                              o_green_value, want.green, want.x, want.y));
                if (o_end_of_line !== want.line_end)
                    report_mismatch($sformatf("end_of_line %b, expected %b at (%0d,%0d)",
                                              o_end_of_line, want.line_end, want.x, want.y));
                if (o_end_of_frame !== want.frame_end)
                    report_mismatch($sformatf("end_of_frame %b, expected %b at (%0d,%0d)",
                                              o_end_of_frame, want.frame_end, want.x, want.y));
            end
        end
    end

    // Ends the run if no transaction moves on either side for too long.
    always @(posedge i_clk) begin : watchdog
        if ((i_valid === 1'b1 && o_stall === 1'b0) || (o_valid === 1'b1 && i_stall === 1'b0)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[video_test_pattern_generator] ERROR");
                $finish;
            end
        end
    end

    initial begin : test_sequence
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = CFG_FRAME_WIDTH;
        i_cfg_wr_data = '0;
        i_valid       = 1'b0;
        i_frame_start = 1'b0;
        frame_w       = RST_FRAME_WIDTH;
        frame_h       = RST_FRAME_HEIGHT;
        pattern       = RST_PATTERN;
        x_step        = RST_X_STEP;
        y_step        = RST_Y_STEP;
        begin_frame();

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_dimension_clamp();
        test_saturating_bands();
        test_bar_saturation();
        test_shrink_mid_frame();
        test_random_frames();

        drain_pipeline();
        repeat (4) @(posedge i_clk);
        if (expected_pixels.size() != 0)
            report_mismatch($sformatf("%0d pixels never arrived", expected_pixels.size()));

        $display("Ran %0d pixel requests and checked %0d pixels over both patterns,",
                 requests_sent, pixels_checked);
        $display("clamped and shrunk frame sizes, saturating and flat ramps, and output stalls.");
        if (mismatch_count == 0)
            $display("[video_test_pattern_generator] OK");
        else
            $display("[video_test_pattern_generator] ERROR");
        $finish;
    end

endmodule

FILE: video_test_pattern_generator.f
sv/vtpg_pkg.sv
sv/vtpg_sat_acc.sv
sv/video_test_pattern_generator.sv
dv/tb_top.sv
